// ===== rtl/rsst_pkg.sv =====
`timescale 1ns / 1ps

package rsst_pkg;

  // Fixed field widths
  localparam int CMD_W = 2;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 42;
  localparam int CFG_W = 11;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_TAKE  = 2'd1,
    CMD_ADD   = 2'd2,
    CMD_SUM   = 2'd3
  } cmd_t;

  typedef enum logic {
    KIND_TAKE = 1'b0,
    KIND_SUM  = 1'b1
  } kind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the input word
    logic clr_wr;     // zero one node of the sweep
    logic rd_leaf;    // read the addressed leaf
    logic wr_leaf;    // write the updated leaf, start the climb
    logic rd_sib;     // read the sibling of the current node
    logic wr_par;     // write the parent sum, move up
    logic sum_init;   // load range pointers, zero accumulator
    logic sum_a;      // left pointer step
    logic sum_b;      // right pointer step and level shift
    logic emit_take;  // result = leaf value just read
    logic emit_zero;  // take-all of an unused entry
    logic emit_sum;   // result = accumulator
  } dp_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic clr_last;
    logic idx_ok;
    logic range_ok;
    logic at_root;
    logic a_lt_b;
  } dp_stat_t;

endpackage

// ===== rtl/rsst_ctrl.sv =====
`timescale 1ns / 1ps

module rsst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output rsst_pkg::dp_ctrl_t ctrl,
  input  rsst_pkg::dp_stat_t stat
);
  import rsst_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_CLEAR   = 10'b00_0000_0010,
    ST_DECODE  = 10'b00_0000_0100,
    ST_LEAF_WR = 10'b00_0000_1000,
    ST_SIB_RD  = 10'b00_0001_0000,
    ST_PAR_WR  = 10'b00_0010_0000,
    ST_SUM_A   = 10'b00_0100_0000,
    ST_SUM_B   = 10'b00_1000_0000,
    ST_SUM_FIN = 10'b01_0000_0000,
    ST_UNUSED  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Reset starts with a clearing sweep of the node store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctrl.capture = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_CLEAR: begin
        ctrl.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_DECODE: begin
        unique case (stat.cmd)
          CMD_CLEAR: state_nxt = ST_CLEAR;
          CMD_TAKE: begin
            if (stat.idx_ok) begin
              ctrl.rd_leaf = 1'b1;
              state_nxt    = ST_LEAF_WR;
            end else begin
              ctrl.emit_zero = 1'b1;
              state_nxt      = ST_IDLE;
            end
          end
          CMD_ADD: begin
            if (stat.idx_ok) begin
              ctrl.rd_leaf = 1'b1;
              state_nxt    = ST_LEAF_WR;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          CMD_SUM: begin
            ctrl.sum_init = 1'b1;
            state_nxt     = stat.range_ok ? ST_SUM_A : ST_SUM_FIN;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_LEAF_WR: begin
        ctrl.wr_leaf = 1'b1;
        if (stat.cmd == CMD_TAKE) ctrl.emit_take = 1'b1;
        state_nxt = ST_SIB_RD;
      end
      ST_SIB_RD: begin
        if (stat.at_root) begin
          state_nxt = ST_IDLE;
        end else begin
          ctrl.rd_sib = 1'b1;
          state_nxt   = ST_PAR_WR;
        end
      end
      ST_PAR_WR: begin
        ctrl.wr_par = 1'b1;
        state_nxt   = ST_SIB_RD;
      end
      ST_SUM_A: begin
        if (stat.a_lt_b) begin
          ctrl.sum_a = 1'b1;
          state_nxt  = ST_SUM_B;
        end else begin
          state_nxt = ST_SUM_FIN;
        end
      end
      ST_SUM_B: begin
        ctrl.sum_b = 1'b1;
        state_nxt  = ST_SUM_A;
      end
      ST_SUM_FIN: begin
        ctrl.emit_sum = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/rsst_datapath.sv =====
`timescale 1ns / 1ps

module rsst_datapath #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rsst_pkg::dp_ctrl_t          ctrl,
  output rsst_pkg::dp_stat_t          stat,
  input  logic [rsst_pkg::CMD_W-1:0]  in_cmd,
  input  logic [rsst_pkg::IDX_W-1:0]  in_left_index,
  input  logic [rsst_pkg::IDX_W-1:0]  in_right_index,
  input  logic [rsst_pkg::VAL_W-1:0]  in_amount,
  input  logic                        cfg_we,
  input  logic [rsst_pkg::CFG_W-1:0]  cfg_wdata,
  output logic                        out_strobe,
  output logic [rsst_pkg::SUM_W-1:0]  out_sum_value,
  output logic                        out_result_kind
);
  import rsst_pkg::*;

  localparam int NODES  = 2 * MAX_ENTRIES;
  localparam int ADDR_W = $clog2(NODES);
  localparam int PTR_W  = $clog2(NODES + 1);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam logic [ADDR_W-1:0] LAST_NODE = ADDR_W'(NODES - 1);
  localparam logic [ADDR_W-1:0] ROOT_NODE = ADDR_W'(1);
  localparam logic [PTR_W-1:0]  LEAF_BASE = PTR_W'(MAX_ENTRIES);
  localparam logic [PTR_W-1:0]  PTR_ONE   = PTR_W'(1);
  localparam logic [CMP_W-1:0]  CMP_ONE   = CMP_W'(1);

  // Registers
  logic [CFG_W-1:0]  active_count_r;
  cmd_t              cmd_r;
  logic [IDX_W-1:0]  li_r, ri_r;
  logic [VAL_W-1:0]  amt_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [ADDR_W-1:0] k_r;
  logic [SUM_W-1:0]  cur_r;
  logic [PTR_W-1:0]  a_r, b_r;
  logic [SUM_W-1:0]  acc_r;
  logic              acc_pend_r;
  logic [SUM_W-1:0]  rdata_r;
  logic              out_strobe_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic              out_kind_r;

  logic [SUM_W-1:0]  mem [NODES];

  // Combinational signals
  logic [CNT_W-1:0]  n_use;
  logic [CMP_W-1:0]  li_c, ri_c, n_c, hi_c;
  logic [ADDR_W-1:0] leaf_addr;
  logic [PTR_W-1:0]  b_dec;
  logic [VAL_W:0]    leaf_add;
  logic [SUM_W-1:0]  new_leaf;
  logic [SUM_W-1:0]  par_sum;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [SUM_W-1:0]  wr_data;

  // Entries in use, clipped to the store size
  always_comb begin
    if (32'(active_count_r) > MAX_ENTRIES) begin
      n_use = CNT_W'(MAX_ENTRIES);
    end else begin
      n_use = CNT_W'(active_count_r);
    end
  end

  // Index checks and range clipping
  assign li_c = CMP_W'(li_r);
  assign ri_c = CMP_W'(ri_r);
  assign n_c  = CMP_W'(n_use);
  assign hi_c = (ri_c < n_c) ? ri_c : (n_c - CMP_ONE);

  assign stat.cmd      = cmd_r;
  assign stat.clr_last = (clr_cnt_r == LAST_NODE);
  assign stat.idx_ok   = (li_c < n_c);
  assign stat.range_ok = (n_c != '0) && (li_c <= hi_c);
  assign stat.at_root  = (k_r == ROOT_NODE);
  assign stat.a_lt_b   = (a_r < b_r);

  assign leaf_addr = ADDR_W'(LEAF_BASE + PTR_W'(li_r));
  assign b_dec     = b_r - PTR_ONE;

  // Leaf update: zero for take-all, saturating add otherwise
  assign leaf_add = {1'b0, rdata_r[VAL_W-1:0]} + {1'b0, amt_r};
  always_comb begin
    if (cmd_r == CMD_TAKE) begin
      new_leaf = '0;
    end else if (leaf_add[VAL_W]) begin
      new_leaf = SUM_W'({VAL_W{1'b1}});
    end else begin
      new_leaf = SUM_W'(leaf_add[VAL_W-1:0]);
    end
  end

  assign par_sum = cur_r + rdata_r;

  // Node store port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = leaf_addr;
    if (ctrl.rd_leaf) begin
      rd_en   = 1'b1;
      rd_addr = leaf_addr;
    end else if (ctrl.rd_sib) begin
      rd_en   = 1'b1;
      rd_addr = k_r ^ ROOT_NODE;
    end else if (ctrl.sum_a) begin
      rd_en   = a_r[0];
      rd_addr = a_r[ADDR_W-1:0];
    end else if (ctrl.sum_b) begin
      rd_en   = b_r[0];
      rd_addr = b_dec[ADDR_W-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = '0;
    if (ctrl.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
    end else if (ctrl.wr_leaf) begin
      wr_en   = 1'b1;
      wr_addr = leaf_addr;
      wr_data = new_leaf;
    end else if (ctrl.wr_par) begin
      wr_en   = 1'b1;
      wr_addr = k_r >> 1;
      wr_data = par_sum;
    end
  end

  // Node store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_count_r <= cfg_wdata;
    end
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r <= cmd_t'(in_cmd);
      li_r  <= in_left_index;
      ri_r  <= in_right_index;
      amt_r <= in_amount;
    end
  end

  // Clear sweep counter, wraps back to zero at the last node
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (ctrl.clr_wr) begin
      clr_cnt_r <= stat.clr_last ? '0 : clr_cnt_r + ROOT_NODE;
    end
  end

  // Climb from the leaf to the root
  always_ff @(posedge clk) begin
    if (ctrl.wr_leaf) begin
      k_r   <= leaf_addr;
      cur_r <= new_leaf;
    end else if (ctrl.wr_par) begin
      k_r   <= k_r >> 1;
      cur_r <= par_sum;
    end
  end

  // Range walk pointers
  always_ff @(posedge clk) begin
    if (ctrl.sum_init) begin
      a_r <= LEAF_BASE + PTR_W'(li_r);
      b_r <= LEAF_BASE + PTR_W'(hi_c) + PTR_ONE;
    end else if (ctrl.sum_a) begin
      if (a_r[0]) a_r <= a_r + PTR_ONE;
    end else if (ctrl.sum_b) begin
      a_r <= a_r >> 1;
      b_r <= (b_r[0] ? b_dec : b_r) >> 1;
    end
  end

  // Accumulate each range read's data in the cycle after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_pend_r <= 1'b0;
    end else begin
      acc_pend_r <= (ctrl.sum_a & a_r[0]) | (ctrl.sum_b & b_r[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_init) begin
      acc_r <= '0;
    end else if (acc_pend_r) begin
      acc_r <= acc_r + rdata_r;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctrl.emit_take | ctrl.emit_zero | ctrl.emit_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_take) begin
      out_sum_r  <= rdata_r;
      out_kind_r <= KIND_TAKE;
    end else if (ctrl.emit_zero) begin
      out_sum_r  <= '0;
      out_kind_r <= KIND_TAKE;
    end else if (ctrl.emit_sum) begin
      out_sum_r  <= acc_r;
      out_kind_r <= KIND_SUM;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_sum_value   = out_sum_r;
  assign out_result_kind = out_kind_r;

endmodule

// ===== rtl/range_sum_segment_tree.sv =====
`timescale 1ns / 1ps

// Segment tree of partial sums over MAX_ENTRIES entries held in one node
// memory (2*MAX_ENTRIES words). A command word is taken when start is high
// and busy is low; one command runs at a time. Add and take-all read the leaf,
// then climb to the root, one sibling read and one parent write per level; a
// new word is taken only once busy falls again. A range sum walks two
// pointers up the tree, level by level over at most log2(MAX_ENTRIES) + 1
// levels. Clear, and likewise reset, sweep the node memory one word a cycle
// with busy high; config writes are taken at any time. Results of take-all
// and range sum appear for exactly one cycle on out_strobe and must be taken
// then: the receiver cannot stall the block.

module range_sum_segment_tree #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [rsst_pkg::CMD_W-1:0]  in_cmd,
  input  logic [rsst_pkg::IDX_W-1:0]  in_left_index,
  input  logic [rsst_pkg::IDX_W-1:0]  in_right_index,
  input  logic [rsst_pkg::VAL_W-1:0]  in_amount,
  output logic                        out_strobe,
  output logic [rsst_pkg::SUM_W-1:0]  out_sum_value,
  output logic                        out_result_kind,
  input  logic                        cfg_we,
  input  logic [rsst_pkg::CFG_W-1:0]  cfg_wdata
);
  import rsst_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  rsst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  rsst_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .in_cmd          (in_cmd),
    .in_left_index   (in_left_index),
    .in_right_index  (in_right_index),
    .in_amount       (in_amount),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_strobe      (out_strobe),
    .out_sum_value   (out_sum_value),
    .out_result_kind (out_result_kind)
  );

endmodule
